>>> design/rcsc_pkg.sv
// Shared types, codes and constants for the radio channel scan controller.
// No dependencies; rcsc_ctrl, rcsc_dp and the top level import this package.
package rcsc_pkg;

  localparam int unsigned SLOT_COUNT_DEF  = 31;
  localparam int unsigned FIXED_SLOTS_DEF = 16;
  localparam int unsigned TABLE_LEN       = 16;

  localparam logic [3:0] FIXED_TABLE [TABLE_LEN] = '{
    4'd1, 4'd6, 4'd11, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5,
    4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13
  };

  localparam logic [15:0] DWELL_RST    = 16'd200;
  localparam logic [31:0] TOTAL_RST    = 32'd0;
  localparam logic [15:0] LOCK_AGE_RST = 16'd8000;

  localparam logic [3:0] CHAN_MIN = 4'd1;
  localparam logic [3:0] CHAN_MAX = 4'd14;

  localparam logic [1:0] CFG_DWELL    = 2'd0;
  localparam logic [1:0] CFG_TOTAL    = 2'd1;
  localparam logic [1:0] CFG_LOCK_AGE = 2'd2;

  typedef enum logic [2:0] {
    MODE_SCANNING = 3'd0,
    MODE_LOCKED   = 3'd1,
    MODE_SUCCESS  = 3'd2,
    MODE_TIMEOUT  = 3'd3,
    MODE_STOPPED  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_FRAME   = 3'd1,
    OP_LOCK    = 3'd2,
    OP_CRED    = 3'd3,
    OP_TARGET  = 3'd4,
    OP_ADD     = 3'd5,
    OP_RESTART = 3'd6,
    OP_STOP    = 3'd7
  } op_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic search;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic search_req;
    logic search_done;
  } dp_sts_t;

  function automatic logic [3:0] slot_init(input logic [6:0] idx, input int unsigned fixed);
    slot_init = (32'(idx) < fixed) ? FIXED_TABLE[idx[3:0]] : 4'd0;
  endfunction

endpackage

>>> design/rcsc_ctrl.sv
// Sequencer for the scan controller: accepts a beat, runs the event and an
// optional slot search, and holds the result register's valid flag. Uses rcsc_pkg.
module rcsc_ctrl import rcsc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEARCH,
    ST_RESULT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   load;

  assign load        = (state_q == ST_RESULT) && (!out_valid_q || out_ready_i);
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  assign cmd_o.capture = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.exec    = (state_q == ST_EXEC);
  assign cmd_o.search  = (state_q == ST_SEARCH);
  assign cmd_o.load    = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q <= sts_i.search_req ? ST_SEARCH : ST_RESULT;
        end
        ST_SEARCH: begin
          if (sts_i.search_done) begin
            state_q <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/rcsc_dp.sv
// Datapath of the scan controller: configuration registers, scan state, age
// counters, the channel slot memory with its search unit, and the result register.
// Uses rcsc_pkg.
module rcsc_dp import rcsc_pkg::*; #(
  parameter int unsigned SLOT_COUNT  = SLOT_COUNT_DEF,
  parameter int unsigned FIXED_SLOTS = FIXED_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic [2:0]  op_i,
  input  logic [3:0]  channel_i,
  input  logic        frame_useful_i,
  output logic [2:0]  scan_state_o,
  output logic [3:0]  current_channel_o,
  output logic [3:0]  lock_channel_o,
  output logic        retune_o,
  output logic        rejected_o
);

  localparam int unsigned PW = $clog2(SLOT_COUNT);
  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (&v) ? v : v + 32'd1;
  endfunction

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] a);
    wrap_inc = (a == PW'(SLOT_COUNT - 1)) ? '0 : a + PW'(1);
  endfunction

  logic [15:0] dwell_ms_q;
  logic [31:0] total_q;
  logic [15:0] lock_lim_q;

  op_e         op_q;
  logic [3:0]  ch_q;
  logic        useful_q;

  mode_e       mode_q;
  logic [PW-1:0] pos_q;
  logic [3:0]  tuned_q;
  logic [3:0]  held_q;
  logic [3:0]  target_q;
  logic [31:0] dwell_age_q;
  logic [31:0] run_age_q;
  logic [31:0] lock_age_q;
  logic        retune_q;
  logic        rejected_q;

  logic [3:0]  mem_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_vld_q;

  logic [3:0]    srch_tgt_q;
  logic [PW-1:0] scan_addr_q;
  logic [CW-1:0] issued_q;
  logic [CW-1:0] exam_q;
  logic          dvalid_q;
  logic [3:0]    rd_raw_q;
  logic          rd_vld_q;
  logic [PW-1:0] rd_addr_q;

  logic [2:0]  scan_state_q;
  logic [3:0]  cur_q;
  logic [3:0]  lock_ch_q;
  logic        retune_out_q;
  logic        rejected_out_q;

  logic        dwell_exp;
  logic        total_exc;
  logic [6:0]  add_sum;
  logic        add_ok;
  logic        add_we;
  logic [PW-1:0] add_idx;
  logic [3:0]  rd_data;
  logic        match;
  logic        srch_done;

  assign dwell_exp = dwell_age_q >= {16'd0, dwell_ms_q};
  // The counters are compared before their increment; a saturated run age
  // never exceeds an all-ones limit.
  assign total_exc = (total_q != 32'd0) && (total_q != '1) && (run_age_q >= total_q);

  assign add_sum = 7'(FIXED_SLOTS) + {3'b000, ch_q};
  assign add_ok  = (ch_q >= CHAN_MIN) && (ch_q <= CHAN_MAX) && (add_sum < 7'(SLOT_COUNT));
  assign add_idx = add_sum[PW-1:0];
  assign add_we  = cmd_i.exec && (op_q == OP_ADD) && add_ok;

  assign rd_data   = rd_vld_q ? rd_raw_q : slot_init(7'(rd_addr_q), FIXED_SLOTS);
  assign match     = (rd_data != 4'd0) && ((srch_tgt_q == 4'd0) || (rd_data == srch_tgt_q));
  assign srch_done = dvalid_q && (match || (exam_q == CW'(SLOT_COUNT - 1)));

  assign sts_o.search_req  = (op_q == OP_TICK) && (mode_q == MODE_SCANNING) && dwell_exp
                             && !total_exc;
  assign sts_o.search_done = srch_done;

  always_ff @(posedge clk_i) begin
    if (add_we) begin
      mem_q[add_idx] <= ch_q;
    end
    if (cmd_i.search) begin
      rd_raw_q  <= mem_q[scan_addr_q];
      rd_vld_q  <= slot_vld_q[scan_addr_q];
      rd_addr_q <= scan_addr_q;
    end
    if (cmd_i.capture) begin
      op_q     <= op_e'(op_i);
      ch_q     <= channel_i;
      useful_q <= frame_useful_i;
    end
    if (cmd_i.load) begin
      scan_state_q   <= mode_q;
      cur_q          <= tuned_q;
      lock_ch_q      <= held_q;
      retune_out_q   <= retune_q;
      rejected_out_q <= rejected_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_ms_q  <= DWELL_RST;
      total_q     <= TOTAL_RST;
      lock_lim_q  <= LOCK_AGE_RST;
      mode_q      <= MODE_SCANNING;
      pos_q       <= '0;
      tuned_q     <= slot_init(7'd0, FIXED_SLOTS);
      held_q      <= 4'd0;
      target_q    <= 4'd0;
      dwell_age_q <= 32'd0;
      run_age_q   <= 32'd0;
      lock_age_q  <= 32'd0;
      retune_q    <= 1'b0;
      rejected_q  <= 1'b0;
      slot_vld_q  <= '0;
      srch_tgt_q  <= 4'd0;
      scan_addr_q <= '0;
      issued_q    <= '0;
      exam_q      <= '0;
      dvalid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_DWELL:    dwell_ms_q <= cfg_data_i[15:0];
          CFG_TOTAL:    total_q    <= cfg_data_i;
          CFG_LOCK_AGE: lock_lim_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (add_we) begin
        slot_vld_q[add_idx] <= 1'b1;
      end
      if (cmd_i.exec) begin
        retune_q   <= 1'b0;
        rejected_q <= 1'b0;
        unique case (op_q)
          OP_TICK: begin
            dwell_age_q <= sat_inc(dwell_age_q);
            run_age_q   <= sat_inc(run_age_q);
            lock_age_q  <= sat_inc(lock_age_q);
            if (dwell_exp) begin
              if (mode_q == MODE_SCANNING) begin
                if (total_exc) begin
                  mode_q <= MODE_TIMEOUT;
                end else begin
                  srch_tgt_q  <= target_q;
                  target_q    <= 4'd0;
                  scan_addr_q <= (target_q != 4'd0) ? pos_q : wrap_inc(pos_q);
                  issued_q    <= '0;
                  exam_q      <= '0;
                  dvalid_q    <= 1'b0;
                end
              end else if (mode_q == MODE_LOCKED && total_exc) begin
                mode_q <= MODE_TIMEOUT;
              end
            end
          end
          OP_FRAME: begin
            if (mode_q == MODE_LOCKED) begin
              if (useful_q) begin
                lock_age_q <= 32'd0;
              end else if (lock_age_q > {16'd0, lock_lim_q}) begin
                mode_q <= MODE_SCANNING;
              end
            end
          end
          OP_LOCK: begin
            held_q <= ch_q;
            if (mode_q == MODE_SCANNING) begin
              mode_q <= MODE_LOCKED;
            end
          end
          OP_CRED: begin
            if (mode_q != MODE_STOPPED) begin
              mode_q <= MODE_SUCCESS;
            end
          end
          OP_TARGET: begin
            target_q <= ch_q;
          end
          OP_ADD: begin
            rejected_q <= !add_ok;
          end
          OP_RESTART: begin
            if (mode_q == MODE_TIMEOUT) begin
              mode_q    <= MODE_SCANNING;
              run_age_q <= 32'd0;
            end
          end
          OP_STOP: begin
            mode_q <= MODE_STOPPED;
          end
          default: ;
        endcase
      end
      if (cmd_i.search) begin
        scan_addr_q <= wrap_inc(scan_addr_q);
        dvalid_q    <= (issued_q != CW'(SLOT_COUNT));
        if (issued_q != CW'(SLOT_COUNT)) begin
          issued_q <= issued_q + CW'(1);
        end
        if (dvalid_q) begin
          exam_q <= exam_q + CW'(1);
        end
        if (srch_done) begin
          if (srch_tgt_q == 4'd0) begin
            pos_q       <= rd_addr_q;
            tuned_q     <= rd_data;
            dwell_age_q <= 32'd0;
            retune_q    <= 1'b1;
          end else if (match && (rd_addr_q != pos_q)) begin
            pos_q       <= rd_addr_q;
            held_q      <= srch_tgt_q;
            tuned_q     <= srch_tgt_q;
            dwell_age_q <= 32'd0;
            mode_q      <= MODE_LOCKED;
            retune_q    <= 1'b1;
          end
        end
      end
    end
  end

  assign scan_state_o      = scan_state_q;
  assign current_channel_o = cur_q;
  assign lock_channel_o    = lock_ch_q;
  assign retune_o          = retune_out_q;
  assign rejected_o        = rejected_out_q;

endmodule

>>> design/radio_channel_scan_controller.sv
// A beat is accepted in the idle state; it then passes the exec state and the result state,
// with the search state between when a dwell expiry walks the slot memory, one slot a cycle.
// The result register is loaded in the result state once the output is free; a new beat
// may be accepted while the previous result still waits in the output register.
// Reset: asynchronous, active low; control and scan state return to their initial values, the slot
// memory's added entries are invalidated by valid bits, and no clearing pass is needed.
module radio_channel_scan_controller import rcsc_pkg::*; #(
  parameter int unsigned SLOT_COUNT  = SLOT_COUNT_DEF,
  parameter int unsigned FIXED_SLOTS = FIXED_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [3:0]  channel_i,
  input  logic        frame_useful_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  scan_state_o,
  output logic [3:0]  current_channel_o,
  output logic [3:0]  lock_channel_o,
  output logic        retune_o,
  output logic        rejected_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  rcsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rcsc_dp #(
    .SLOT_COUNT  (SLOT_COUNT),
    .FIXED_SLOTS (FIXED_SLOTS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .op_i              (op_i),
    .channel_i         (channel_i),
    .frame_useful_i    (frame_useful_i),
    .scan_state_o      (scan_state_o),
    .current_channel_o (current_channel_o),
    .lock_channel_o    (lock_channel_o),
    .retune_o          (retune_o),
    .rejected_o        (rejected_o)
  );

endmodule

>>> design/rcsc_checker.sv
// Port-level assertions for the radio channel scan controller, bound to its top level.
// Depends only on the top level's ports.
module rcsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  scan_state_o,
  input logic [3:0]  current_channel_o,
  input logic [3:0]  lock_channel_o,
  input logic        retune_o,
  input logic        rejected_o
);

  // A beat is worked on alone, so ready drops right after an accept.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a beat is in progress");

  a_tuned_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> current_channel_o != 4'd0)
    else $error("result shows an empty channel as tuned");

  a_retune_reject_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(retune_o && rejected_o))
    else $error("one beat both retuned and rejected");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(scan_state_o)
      && $stable(current_channel_o) && $stable(lock_channel_o)
      && $stable(retune_o) && $stable(rejected_o))
    else $error("stalled result changed or dropped");

endmodule

bind radio_channel_scan_controller rcsc_checker u_rcsc_checker (.*);
